FILE: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants for the radix digit converter
// Controller/datapath command and status words, state codes, digit encoding.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int unsigned RADIX_W        = 5;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned DIGIT_W        = 4;
  // division bits resolved per clock by the shared divider
  localparam int unsigned BITS_PER_CYCLE = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] ASCII_ALPHA = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] ERROR_CHAR  = 7'h00;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_COMMIT = 5'b00100,
    ST_PRIME  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;     // capture a new word
    logic step;     // one divider iteration
    logic commit;   // store remainder, start next digit
    logic advance;  // current digit taken, move to next one
  } cmd_t;

  typedef struct packed {
    logic radix_bad;   // incoming radix outside 2..16
    logic quot_zero;   // quotient register is zero
    logic store_full;  // this commit fills the digit store
    logic ptr_zero;    // emitting the least significant digit
  } status_t;

  // 0..15 -> '0'..'9','A'..'F'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      digit_to_ascii = ASCII_ZERO + ext;
    end else begin
      digit_to_ascii = ASCII_ALPHA + ext - CHAR_W'(10);
    end
  endfunction

endpackage

FILE: rtl/rdc_in_if.sv
// ----------------------------------------------------------------------------
// rdc_in_if: input channel of the radix digit converter
// Valid/ready handshake carrying the value and the target radix.
// ----------------------------------------------------------------------------
interface rdc_in_if #(
  parameter int unsigned VALUE_WIDTH = 31
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [4:0]             radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

FILE: rtl/rdc_out_if.sv
// ----------------------------------------------------------------------------
// rdc_out_if: output channel of the radix digit converter
// Valid/ready handshake carrying one ASCII digit with last and error flags.
// ----------------------------------------------------------------------------
interface rdc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last;
  logic       error;

  modport source (output valid, output digit_char, output last, output error, input ready);
  modport sink   (input valid, input digit_char, input last, input error, output ready);
endinterface

FILE: rtl/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_converter: integer to radix string converter
// Converts an unsigned value to ASCII digits in radix 2..16, MSD first.
// ----------------------------------------------------------------------------
//
//  channel | dir | word contents                     | accepted when
//  --------+-----+-----------------------------------+------------------------
//  in_i    | in  | value, radix                      | valid & ready
//  out_o   | out | digit_char, last, error           | valid & ready
//
//  The divider resolves 8 quotient bits per clock; each digit takes a run of
//  divider steps and then a commit. A prime state then starts the digit store
//  read, then one digit per cycle goes out while out_o is ready.
//  The longest conversion at defaults is radix 2, 31 digits.
//  A bad radix gives one error word the cycle after acceptance.
//  Reset clears the controller and counters; the digit store is not cleared
//  (only entries written by the current conversion are ever read).
//  One word at a time: in_i.ready is high only while idle. A stall on out_o
//  holds the current digit; nothing is dropped.
//
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 31,
  parameter int unsigned DIGIT_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rdc_in_if.sink        in_i,
  rdc_out_if.source     out_o
);

  localparam int unsigned NUM_STEPS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;

  cmd_t    cmd;
  status_t status;

  // controller: sequencing only, no payload
  rdc_ctrl #(
    .NUM_STEPS (NUM_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: divider, digit store, output payload decoded from registers
  rdc_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (in_i.value),
    .radix_i      (in_i.radix),
    .cmd_i        (cmd),
    .status_o     (status),
    .digit_char_o (out_o.digit_char),
    .last_o       (out_o.last),
    .error_o      (out_o.error)
  );

endmodule

FILE: rtl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl: sequencing state machine
// Steps the divider per digit, commits digits, then drives the emit phase;
// a bad radix goes straight from idle to the emit phase.
module rdc_ctrl
  import rdc_pkg::*;
#(
  parameter int unsigned NUM_STEPS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int unsigned STEP_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step;

  assign last_step = (step_q == STEP_W'(NUM_STEPS - 1));

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = status_i.radix_bad ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (last_step) begin
          state_d = ST_COMMIT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        step_d       = '0;
        state_d      = (status_i.quot_zero || status_i.store_full) ? ST_PRIME : ST_DIV;
      end
      ST_PRIME: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.ptr_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/rdc_dp.sv
// ----------------------------------------------------------------------------
// rdc_dp: divider, digit store and output payload
// Restoring division by the radix, BITS_PER_CYCLE quotient bits per clock.
// ----------------------------------------------------------------------------
module rdc_dp
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH,
  parameter int unsigned DIGIT_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [RADIX_W-1:0]     radix_i,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  output logic [CHAR_W-1:0]      digit_char_o,
  output logic                   last_o,
  output logic                   error_o
);

  localparam int unsigned NUM_STEPS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int unsigned ACC_W     = NUM_STEPS * BITS_PER_CYCLE;
  localparam int unsigned ADDR_W    = $clog2(DIGIT_DEPTH);

  logic [ACC_W-1:0]   acc_q, acc_d;       // dividend bits in, quotient bits out
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] radix_q;
  logic               err_q;
  logic [ADDR_W-1:0]  cnt_q;              // next store index
  logic [ADDR_W-1:0]  ptr_q;              // digit being emitted
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIGIT_W-1:0] rd_data_q;
  logic [DIGIT_W-1:0] mem [DIGIT_DEPTH];
  logic               radix_bad;

  assign radix_bad = (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX);

  // one step of restoring division; remainder stays below the radix
  always_comb begin
    logic [ACC_W-1:0]   a;
    logic [RADIX_W-1:0] r;
    logic [RADIX_W-1:0] t;
    a = acc_q;
    r = rem_q;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      t = {r[RADIX_W-2:0], a[ACC_W-1]};
      a = {a[ACC_W-2:0], 1'b0};
      if (t >= radix_q) begin
        r    = t - radix_q;
        a[0] = 1'b1;
      end else begin
        r = t;
      end
    end
    acc_d = a;
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      err_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        ptr_q <= '0;
        err_q <= radix_bad;
      end else if (cmd_i.commit) begin
        cnt_q <= cnt_q + ADDR_W'(1);
        ptr_q <= cnt_q;
      end else if (cmd_i.advance) begin
        ptr_q <= ptr_q - ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q   <= ACC_W'(value_i);
      rem_q   <= '0;
      radix_q <= radix_i;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end else if (cmd_i.commit) begin
      rem_q <= '0;
    end
  end

  // digit store, remainders least significant first
  assign rd_addr = cmd_i.advance ? (ptr_q - ADDR_W'(1)) : ptr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem[cnt_q] <= rem_q[DIGIT_W-1:0];
    end
    rd_data_q <= mem[rd_addr];
  end

  assign status_o.radix_bad  = radix_bad;
  assign status_o.quot_zero  = (acc_q == '0);
  assign status_o.store_full = (cnt_q == ADDR_W'(DIGIT_DEPTH - 1));
  assign status_o.ptr_zero   = (ptr_q == '0);

  assign digit_char_o = err_q ? ERROR_CHAR : digit_to_ascii(rd_data_q);
  assign last_o       = (ptr_q == '0);
  assign error_o      = err_q;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for radix_digit_converter
// Feeds value/radix words through a valid/ready driver with random gaps,
// predicts the ASCII digit words of each conversion and checks every output
// word in order, under random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import rdc_pkg::*;

  localparam int unsigned VALUE_W     = 31;
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned RANDOM_WORDS = 260;
  // limit allows for the longest word plus stalls on up to 31 digits,
  // taken many times over
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam string DIGIT_GLYPHS = "0123456789ABCDEF";

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } conv_req_t;

  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              error;
  } digit_word_t;

  logic clk_i;
  logic rst_ni;

  rdc_in_if #(.VALUE_WIDTH(VALUE_W)) in_bus ();
  rdc_out_if                         out_bus ();

  radix_digit_converter #(
    .VALUE_WIDTH(VALUE_W),
    .DIGIT_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  conv_req_t   pending_reqs[$];   // words not yet offered
  digit_word_t digit_q[$];        // predicted digits, oldest first
  int unsigned errors;
  int unsigned words_taken;
  int unsigned cycle_count;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          in_calm;           // stretch with no input gaps
  bit          out_calm;          // stretch with no output stalls
  logic        hold_off;          // long output hold, own process
  conv_req_t   next_req;
  digit_word_t seen;
  digit_word_t want;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Gap length: mostly zero or short, now and then long.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Expected digit words for one conversion, pushed onto digit_q.
  function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    logic [3:0]         rems[STORE_DEPTH];
    logic [VALUE_W-1:0] quot;
    int unsigned        ndig;
    int unsigned        base;
    digit_word_t        w;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      // bad radix: a single flagged word, no digits
      w.digit_char = ERROR_CHAR;
      w.last       = 1'b1;
      w.error      = 1'b1;
      digit_q.push_back(w);
      return;
    end
    base = 32'(radix);
    quot = value;
    ndig = 0;
    if (quot == '0) begin
      rems[0] = 4'd0;
      ndig    = 1;
    end
    while (quot != '0 && ndig < STORE_DEPTH) begin
      rems[ndig] = 4'(quot % base);
      quot       = VALUE_W'(quot / base);
      ndig++;
    end
    // remainders come out least significant first; send MSD first
    for (int k = int'(ndig) - 1; k >= 0; k--) begin
      w.digit_char = CHAR_W'(DIGIT_GLYPHS[rems[k]]);
      w.last       = (k == 0);
      w.error      = 1'b0;
      digit_q.push_back(w);
    end
  endfunction

  function automatic void queue_req(input logic [VALUE_W-1:0] value,
                                    input logic [RADIX_W-1:0] radix);
    conv_req_t r;
    r.value = value;
    r.radix = radix;
    pending_reqs.push_back(r);
  endfunction

  // Random word: mostly good radix, value spread from tiny to full width.
  function automatic void queue_random_req();
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] rx;
    int unsigned        r;
    if ($urandom_range(0, 99) < 85) begin
      rx = RADIX_W'($urandom_range(2, 16));
    end else begin
      // 0, 1 or 17..31
      r = $urandom_range(0, 16);
      if (r >= 2) r += 15;
      rx = RADIX_W'(r);
    end
    case ($urandom_range(0, 9))
      0:       v = VALUE_W'($urandom_range(0, 20));
      1:       v = VALUE_W'($urandom_range(0, 300));
      2:       v = {VALUE_W{1'b1}};
      3:       v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      4:       v = VALUE_W'($urandom) >> $urandom_range(0, VALUE_W - 1);
      default: v = VALUE_W'($urandom);
    endcase
    queue_req(v, rx);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers pending words, holds them until taken, random gaps between.
  // Every input signal gets at most one NBA per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_digits(in_bus.value, in_bus.radix);
        words_taken++;
      end
      // slot free when nothing offered or the offered word just went in
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          in_bus.value <= next_req.value;
          in_bus.radix <= next_req.radix;
          in_bus.valid <= 1'b1;
          gap_left = in_calm ? 0 : draw_gap();
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken output word against the oldest prediction,
  // then decides ready for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen.digit_char = out_bus.digit_char;
        seen.last       = out_bus.last;
        seen.error      = out_bus.error;
        if (digit_q.size() == 0) begin
          $display("%0t: unexpected digit word char=%h last=%b error=%b",
                   $time, seen.digit_char, seen.last, seen.error);
          errors++;
        end else begin
          want = digit_q.pop_front();
          if (seen.digit_char !== want.digit_char) begin
            $display("%0t: digit_char expected %h actual %h",
                     $time, want.digit_char, seen.digit_char);
            errors++;
          end
          if (seen.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, seen.last);
            errors++;
          end
          if (seen.error !== want.error) begin
            $display("%0t: error expected %b actual %b", $time, want.error, seen.error);
            errors++;
          end
        end
      end
      if (hold_off) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) stall_left = draw_gap();
        if ($urandom_range(0, 59) == 0) out_calm = !out_calm;
      end
    end
  end

  // Long output hold once the directed words are through: the converter
  // stalls in the emit phase and the driver keeps offering against a low in ready.
  initial begin
    hold_off = 1'b0;
    while (words_taken < 30) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d digit words still expected", $time, digit_q.size());
      $display("FAIL radix_digit_converter");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    errors        = 0;
    words_taken   = 0;
    cycle_count   = 0;
    gap_left      = 0;
    stall_left    = 0;
    in_calm       = 1'b0;
    out_calm      = 1'b0;
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    in_bus.radix  = '0;
    out_bus.ready = 1'b0;

    // zero value gives the single digit '0'
    queue_req('0, 5'd2);
    queue_req('0, 5'd10);
    queue_req('0, 5'd16);
    // full-scale value: 31 binary digits is the longest conversion
    queue_req({VALUE_W{1'b1}}, 5'd2);
    queue_req({VALUE_W{1'b1}}, 5'd3);
    queue_req({VALUE_W{1'b1}}, 5'd10);
    queue_req({VALUE_W{1'b1}}, 5'd16);
    queue_req(VALUE_W'(1), 5'd2);
    queue_req(VALUE_W'(15), 5'd16);
    queue_req(VALUE_W'(16), 5'd16);
    queue_req(VALUE_W'(255), 5'd16);
    queue_req(VALUE_W'(24'hABCDEF), 5'd16);
    queue_req(VALUE_W'(1) << (VALUE_W - 1), 5'd2);
    queue_req(VALUE_W'(12345), 5'd7);
    queue_req(VALUE_W'(987654), 5'd13);
    queue_req(VALUE_W'(99), 5'd9);
    // radix out of range: one flagged word, whatever the value
    queue_req(VALUE_W'(42), 5'd0);
    queue_req({VALUE_W{1'b1}}, 5'd1);
    queue_req(VALUE_W'(100), 5'd17);
    queue_req('0, 5'd31);
    queue_req(VALUE_W'(7), 5'd0);
    // good word straight after an error
    queue_req(VALUE_W'(1000), 5'd10);

    for (int i = 0; i < RANDOM_WORDS; i++) queue_random_req();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything offered and taken, every digit seen
    while (pending_reqs.size() != 0 || in_bus.valid || digit_q.size() != 0)
      @(posedge clk_i);
    // settle: catch any stray trailing word
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (digit_q.size() != 0) begin
      $display("%0t: %0d digit words never arrived", $time, digit_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS radix_digit_converter");
    end else begin
      $display("FAIL radix_digit_converter");
    end
    $finish;
  end

endmodule
